// File: hw/rtl/sm4_pkg.sv
// Shared types, register codes and SM4 constants for the SM4 register device.
// No dependencies; used by the controller, datapath and top level.
package sm4_pkg;

  // One bus access.
  typedef struct packed {
    logic        kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } req_t;

  // One response.
  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
  } rsp_t;

  // Register offsets.
  localparam logic [3:0] RegCtrl   = 4'd0;
  localparam logic [3:0] RegStatus = 4'd1;
  localparam logic [3:0] RegKey0   = 4'd2;
  localparam logic [3:0] RegKey3   = 4'd5;
  localparam logic [3:0] RegData0  = 4'd6;
  localparam logic [3:0] RegData3  = 4'd9;
  localparam logic [3:0] RegRes0   = 4'd10;
  localparam logic [3:0] RegRes3   = 4'd13;

  localparam logic KindWrite = 1'b1;

  // Control bit positions.
  localparam int CEn   = 0;
  localparam int CDec  = 1;
  localparam int CKexp = 2;
  localparam int CKval = 3;
  localparam int CRun  = 4;
  localparam int CDval = 5;
  localparam int SKrdy = 0;
  localparam int SRval = 1;

  localparam logic [31:0] Fk0 = 32'hA3B1BAC6;
  localparam logic [31:0] Fk1 = 32'h56AA3350;
  localparam logic [31:0] Fk2 = 32'h677D9197;
  localparam logic [31:0] Fk3 = 32'hB27022DC;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       access;   // perform register access of the request
    logic       key_init; // load key schedule state from key words
    logic       key_step; // one key expansion round
    logic       txt_init; // load cipher state from data words
    logic       txt_step; // one cipher round
    logic       finish;   // write result words
    logic [4:0] round;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic start;   // access started a block
    logic kexp;    // key expansion requested
  } sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };
    return t[a];
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] x);
    return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

  // Round constant: byte j of CK[i] is 7*(4i+j) mod 256.
  function automatic logic [31:0] ck_word(input logic [4:0] i);
    logic [7:0] b0;
    b0 = {1'b0, i, 2'b00} * 8'd7;
    return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

endpackage

// File: hw/rtl/sm4_ctrl.sv
// Controller state machine for the SM4 register device.
// Depends on sm4_pkg; drives the datapath through cmd_t, reads sts_t.
module sm4_ctrl
  import sm4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_KINI = 6'b000010,
    S_KEXP = 6'b000100,
    S_TINI = 6'b001000,
    S_TRND = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [4:0] round, round_next;
  logic       out_valid_next;
  logic       take;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign take     = in_valid && !in_stall;

  // Next state and commands.
  always_comb begin
    state_next     = state;
    round_next     = round;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.round      = round;
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd.access = 1'b1;
          if (sts.start) begin
            state_next = sts.kexp ? S_KINI : S_TINI;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_KINI: begin
        cmd.key_init = 1'b1;
        round_next   = '0;
        state_next   = S_KEXP;
      end
      S_KEXP: begin
        cmd.key_step = 1'b1;
        round_next   = round + 5'd1;
        if (round == 5'd31) state_next = S_TINI;
      end
      S_TINI: begin
        cmd.txt_init = 1'b1;
        round_next   = '0;
        state_next   = S_TRND;
      end
      S_TRND: begin
        cmd.txt_step = 1'b1;
        round_next   = round + 5'd1;
        if (round == 5'd31) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish     = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      round     <= round_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: hw/rtl/sm4_dp.sv
// Datapath of the SM4 register device: register file, round key store and round logic.
// Depends on sm4_pkg; commanded by sm4_ctrl.
module sm4_dp
  import sm4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  logic [5:0]  control_bits;
  logic [1:0]  status_bits;
  logic [31:0] key_words [4];
  logic [31:0] data_words [4];
  logic [31:0] result_words [4];
  logic [31:0] rk_mem [32];
  logic [31:0] st [4];
  logic [5:0]  ctrl_new;
  logic [1:0]  idx;
  logic [31:0] rk, ka, kb, ta, tb, rd;
  logic        err;
  logic [4:0]  rk_addr;

  assign ctrl_new = req.write_data[CEn] ? req.write_data[5:0] : 6'd0;
  assign idx      = req.reg_index[1:0] - 2'd2;
  assign sts.start = req.kind == KindWrite && req.reg_index == RegCtrl &&
                     ctrl_new[CEn] && ctrl_new[CRun] && ctrl_new[CKval] && ctrl_new[CDval];
  assign sts.kexp  = ctrl_new[CKexp];

  // Round key selection; decryption walks the store backward.
  assign rk_addr = control_bits[CDec] ? ~cmd.round : cmd.round;
  assign rk = rk_mem[rk_addr];

  // Key expansion round.
  assign ka = tau(st[1] ^ st[2] ^ st[3] ^ ck_word(cmd.round));
  assign kb = st[0] ^ ka ^ {ka[18:0], ka[31:19]} ^ {ka[8:0], ka[31:9]};
  // Cipher round.
  assign ta = tau(st[1] ^ st[2] ^ st[3] ^ rk);
  assign tb = st[0] ^ ta ^ {ta[29:0], ta[31:30]} ^ {ta[21:0], ta[31:22]} ^
              {ta[13:0], ta[31:14]} ^ {ta[7:0], ta[31:8]};

  // Access decode: read data and access error.
  always_comb begin
    rd  = '0;
    err = 1'b0;
    if (req.kind == KindWrite) begin
      if (req.reg_index == RegCtrl) err = 1'b0;
      else if (req.reg_index >= RegKey0 && req.reg_index <= RegData3) err = !control_bits[CEn];
      else err = 1'b1;
    end else begin
      if (req.reg_index == RegCtrl) rd = {26'd0, control_bits};
      else if (req.reg_index == RegStatus) rd = {30'd0, status_bits};
      else if (req.reg_index <= RegKey3) begin
        if (control_bits[CKval]) rd = key_words[idx];
        else err = 1'b1;
      end else if (req.reg_index <= RegData3) begin
        if (control_bits[CDval]) rd = data_words[idx];
        else err = 1'b1;
      end else if (req.reg_index <= RegRes3) begin
        if (status_bits[SRval]) rd = result_words[idx];
        else err = 1'b1;
      end else err = 1'b1;
    end
  end

  // Control and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits <= '0;
      status_bits  <= '0;
    end else begin
      if (cmd.access && req.kind == KindWrite && req.reg_index == RegCtrl) begin
        control_bits <= ctrl_new;
        if (!ctrl_new[CEn]) status_bits <= '0;
      end
      if (cmd.key_step && cmd.round == 5'd31) status_bits[SKrdy] <= 1'b1;
      if (cmd.finish) status_bits[SRval] <= 1'b1;
    end
  end

  // Register file words, result words and the round key store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_words[i]    <= '0;
        data_words[i]   <= '0;
        result_words[i] <= '0;
      end
      for (int i = 0; i < 32; i++) rk_mem[i] <= '0;
    end else begin
      if (cmd.access && req.kind == KindWrite && control_bits[CEn]) begin
        if (req.reg_index >= RegKey0 && req.reg_index <= RegKey3) key_words[idx] <= req.write_data;
        if (req.reg_index >= RegData0 && req.reg_index <= RegData3)
          data_words[idx] <= req.write_data;
      end
      if (cmd.key_step) rk_mem[cmd.round] <= kb;
      if (cmd.finish) begin
        result_words[0] <= st[3];
        result_words[1] <= st[2];
        result_words[2] <= st[1];
        result_words[3] <= st[0];
      end
    end
  end

  // Round state and response register.
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      rsp.read_data    <= rd;
      rsp.access_error <= err;
    end
    if (cmd.key_init) begin
      st[0] <= key_words[0] ^ Fk0;
      st[1] <= key_words[1] ^ Fk1;
      st[2] <= key_words[2] ^ Fk2;
      st[3] <= key_words[3] ^ Fk3;
    end else if (cmd.txt_init) begin
      for (int i = 0; i < 4; i++) st[i] <= data_words[i];
    end else if (cmd.key_step || cmd.txt_step) begin
      st[0] <= st[1];
      st[1] <= st[2];
      st[2] <= st[3];
      st[3] <= cmd.key_step ? kb : tb;
    end
  end

endmodule

// File: hw/rtl/sm4_cipher_register_device_unit.sv
// Top level of the SM4 register device: controller plus datapath.
// Depends on sm4_pkg, sm4_ctrl and sm4_dp.
//
// A 32-bit register file in front of a single-block SM4 ECB engine. Each request
// transaction is one register read or write and gives one response transaction.
// Ordinary accesses are answered from a registered response. A control write that starts a
// block runs one round per cycle through shared round state registers: a load and 32
// key expansion rounds when requested, then a load, 32 cipher rounds and a store of the
// result; no request is taken meanwhile.
module sm4_cipher_register_device_unit
  import sm4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  cmd_t cmd;
  sts_t sts;

  sm4_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  sm4_dp u_dp (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );

endmodule
